@@ rtl/csmth_pkg.sv @@
// Package for the cave smoothing automaton: tile codes, sizes, register and
// function codes, and the word type passed from the position stage to the filter.
// No dependencies.
package csmth_pkg;

   // storage bounds
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
   localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);

   // field and register widths
   localparam int CELL_W   = 8;
   localparam int LINE_W   = 2 * CELL_W;
   localparam int GW_W     = 9;
   localparam int GH_W     = 13;
   localparam int LIMIT_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   // tile codes
   localparam logic [CELL_W-1:0] TILE_WALL  = 8'h23;
   localparam logic [CELL_W-1:0] TILE_FLOOR = 8'h2E;

   // geometry clamps
   localparam logic [GW_W-1:0] MIN_GW = GW_W'(3);
   localparam logic [GW_W-1:0] MAX_GW = GW_W'(MAX_WIDTH);
   localparam logic [GH_W-1:0] MIN_GH = GH_W'(3);
   localparam logic [GH_W-1:0] MAX_GH = GH_W'(MAX_HEIGHT);

   // reset values of the registers
   localparam logic [GW_W-1:0]    RST_GW    = GW_W'(64);
   localparam logic [GH_W-1:0]    RST_GH    = GH_W'(64);
   localparam logic [LIMIT_W-1:0] RST_CLOSE = LIMIT_W'(1);
   localparam logic [LIMIT_W-1:0] RST_OPEN  = LIMIT_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_CLOSE_LIMIT = 2'd2,
      CSR_OPEN_LIMIT  = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_CELL  = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   // one word in flight between the position stage and the filter stage
   typedef struct packed {
      logic              emit;
      logic              border;
      logic              last;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] tile;
   } item_type;

endpackage

@@ rtl/csmth_front.sv @@
// Position stage of the cave smoothing automaton: input and output raster
// counters, line store read issue and the register feeding the filter stage.
// Depends on csmth_pkg.
module csmth_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [csmth_pkg::CELL_W-1:0]      req_cell_in,
   input  logic [csmth_pkg::GW_W-1:0]        grid_width,
   input  logic [csmth_pkg::GH_W-1:0]        grid_height,
   input  logic                              restart,
   input  logic                              b_go,
   output logic                              b_valid,
   output csmth_pkg::item_type               b_item,
   output logic                              rd_en,
   output logic [csmth_pkg::COL_W-1:0]       rd_addr
);

   logic [csmth_pkg::COL_W-1:0]     in_col_ff, in_col_in;
   logic [csmth_pkg::ROW_W-1:0]     in_row_ff, in_row_in;
   logic [csmth_pkg::COL_W-1:0]     out_col_ff, out_col_in;
   logic [csmth_pkg::OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic                            b_valid_ff, b_valid_in;
   csmth_pkg::item_type             b_item_ff, b_item_in;

   logic                            drain;
   logic                            accept;
   logic                            to_b;
   logic                            emit;
   logic                            col_end;
   logic                            out_col_end;
   logic                            out_row_end;
   logic [csmth_pkg::GW_W-1:0]      in_col_nx;
   logic [csmth_pkg::GW_W-1:0]      out_col_nx;
   logic [csmth_pkg::GW_W-1:0]      width_m1;
   logic [csmth_pkg::GH_W-1:0]      height_m1;

   // handshake: hold the input while the filter stage cannot move
   assign req_stall = b_valid_ff && !b_go;
   assign accept    = req_valid && !req_stall;
   assign drain     = in_row_ff >= csmth_pkg::ROW_W'(grid_height);
   // a drain word before the layer is complete is dropped here
   assign to_b      = accept && (drain || req_func == csmth_pkg::FUNC_CELL);

   assign rd_en   = to_b;
   assign rd_addr = in_col_ff;

   // positions and edge tests
   assign width_m1    = grid_width - csmth_pkg::GW_W'(1);
   assign height_m1   = grid_height - csmth_pkg::GH_W'(1);
   assign in_col_nx   = {1'b0, in_col_ff} + csmth_pkg::GW_W'(1);
   assign out_col_nx  = {1'b0, out_col_ff} + csmth_pkg::GW_W'(1);
   assign col_end     = in_col_nx >= grid_width;
   assign out_col_end = {1'b0, out_col_ff} >= width_m1;
   assign out_row_end = {1'b0, out_row_ff} >= height_m1;
   assign emit        = (in_row_ff >= csmth_pkg::ROW_W'(2)) ||
                        (in_row_ff == csmth_pkg::ROW_W'(1) && in_col_ff != '0);

   // build the word for the filter stage
   always_comb begin
      b_item_in.emit   = emit;
      b_item_in.border = out_row_ff == '0 || out_col_ff == '0 || out_row_end || out_col_end;
      b_item_in.last   = out_row_end && out_col_end;
      b_item_in.col    = in_col_ff;
      b_item_in.tile   = drain ? '0 : req_cell_in;
   end

   // advance the raster counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (to_b) begin
         if (col_end) begin
            in_col_in = '0;
            in_row_in = in_row_ff + csmth_pkg::ROW_W'(1);
         end else begin
            in_col_in = in_col_nx[csmth_pkg::COL_W-1:0];
         end
         if (emit) begin
            if (b_item_in.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_nx >= grid_width) begin
               out_col_in = '0;
               out_row_in = out_row_ff + csmth_pkg::OUT_ROW_W'(1);
            end else begin
               out_col_in = out_col_nx[csmth_pkg::COL_W-1:0];
            end
         end
      end
   end

   // stage register occupancy
   always_comb begin
      if (to_b) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // payload register, loaded on each word sent on
   always_ff @(posedge clock) begin
      if (to_b) begin
         b_item_ff <= b_item_in;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_item  = b_item_ff;

endmodule

@@ rtl/csmth_filter.sv @@
// Filter stage of the cave smoothing automaton: two-row line store memory with
// write forwarding, the 3x3 window, the neighbor count rule and the output register.
// Depends on csmth_pkg.
module csmth_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              b_valid,
   input  csmth_pkg::item_type               b_item,
   input  logic                              rd_en,
   input  logic [csmth_pkg::COL_W-1:0]       rd_addr,
   input  logic [csmth_pkg::LIMIT_W-1:0]     close_limit,
   input  logic [csmth_pkg::LIMIT_W-1:0]     open_limit,
   output logic                              b_go,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [csmth_pkg::CELL_W-1:0]      rsp_cell_out,
   output logic                              rsp_frame_end
);

   // upper half: two rows up, lower half: one row up
   logic [csmth_pkg::LINE_W-1:0]   line_mem [csmth_pkg::MAX_WIDTH];
   logic [csmth_pkg::LINE_W-1:0]   rd_data_ff;
   logic [csmth_pkg::LINE_W-1:0]   fwd_data_ff;
   logic                           hit_ff;
   logic [csmth_pkg::LINE_W-1:0]   line_word;
   logic [csmth_pkg::LINE_W-1:0]   wr_data;
   logic                           wr_en;

   logic [csmth_pkg::CELL_W-1:0]   win_ff [9];
   logic [csmth_pkg::CELL_W-1:0]   win_in [9];
   logic [csmth_pkg::CELL_W-1:0]   up1;
   logic [csmth_pkg::CELL_W-1:0]   up2;
   logic [csmth_pkg::CELL_W-1:0]   center;
   logic [csmth_pkg::CELL_W-1:0]   result;
   logic [csmth_pkg::LIMIT_W-1:0]  count;

   logic                           rsp_valid_ff;
   logic [csmth_pkg::CELL_W-1:0]   rsp_cell_ff;
   logic                           rsp_end_ff;

   // move when the word yields nothing or the output register frees up
   assign b_go = b_valid && (!b_item.emit || !rsp_valid_ff || !rsp_stall);

   // line store: take the write made in the read's cycle if it hit the address read
   assign line_word = hit_ff ? fwd_data_ff : rd_data_ff;
   assign up2       = line_word[csmth_pkg::LINE_W-1:csmth_pkg::CELL_W];
   assign up1       = line_word[csmth_pkg::CELL_W-1:0];
   assign wr_en     = b_go;
   assign wr_data   = {up1, b_item.tile};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[b_item.col] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= line_mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= wr_en && (b_item.col == rd_addr);
      end
   end

   // shift the window left and bring in the new column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = up2;
      win_in[5] = up1;
      win_in[8] = b_item.tile;
   end

   // count floor neighbors around the center
   always_comb begin
      count = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && win_in[k] == csmth_pkg::TILE_FLOOR) begin
            count = count + csmth_pkg::LIMIT_W'(1);
         end
      end
   end

   // apply the open and close rule; close wins
   assign center = win_in[4];
   always_comb begin
      result = center;
      if (!b_item.border &&
          (center == csmth_pkg::TILE_WALL || center == csmth_pkg::TILE_FLOOR)) begin
         if (count >= open_limit) begin
            result = csmth_pkg::TILE_FLOOR;
         end
         if (count <= close_limit) begin
            result = csmth_pkg::TILE_WALL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (b_go) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // output register: load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go && b_item.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go && b_item.emit) begin
         rsp_cell_ff <= result;
         rsp_end_ff  <= b_item.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_out  = rsp_cell_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

@@ rtl/cave_smoothing_automaton.sv @@
// Top level of the cave smoothing automaton: configuration registers and the
// position and filter stages. Depends on csmth_pkg, csmth_front, csmth_filter.
//
// Usage:
//  - req_ channel: one word per handshake (req_valid high, req_stall low).
//    req_func selects a cell byte in raster order or a drain step; drain
//    steps push out the last width+1 results of a layer. A drain before the
//    layer is complete is taken and yields nothing.
//  - rsp_ channel: one smoothed cell per word; rsp_frame_end marks the last
//    cell of the layer, after which the next layer starts.
//  - csr_ port: write grid_width, grid_height, close_limit, open_limit by
//    index, only while the block is idle; a geometry write restarts the layer.
//  - Throughput: one word per cycle while req_stall stays low, set by the single
//    read and single write port of the line store, used once per word.
//  - Latency: a result passes the position stage and output registers before
//    it shows on rsp_; in words the output lags the input by width+1 cells.
//  - Reset: synchronous; clears positions and window and loads the register
//    defaults (64 x 64, close 1, open 4). The line store is not cleared.
//  - Stall: a result waits in the output register; one more word is taken
//    into the position stage register, then req_stall rises until rsp_stall drops.
module cave_smoothing_automaton (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [csmth_pkg::CELL_W-1:0]      req_cell_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [csmth_pkg::CELL_W-1:0]      rsp_cell_out,
   output logic                              rsp_frame_end,
   input  logic                              csr_write_en,
   input  logic [csmth_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csmth_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   logic [csmth_pkg::GW_W-1:0]    grid_width_ff, grid_width_in;
   logic [csmth_pkg::GH_W-1:0]    grid_height_ff, grid_height_in;
   logic [csmth_pkg::LIMIT_W-1:0] close_limit_ff, close_limit_in;
   logic [csmth_pkg::LIMIT_W-1:0] open_limit_ff, open_limit_in;
   logic [csmth_pkg::GW_W-1:0]    wr_width;
   logic [csmth_pkg::GH_W-1:0]    wr_height;
   logic                          restart;

   logic                          b_go;
   logic                          b_valid;
   csmth_pkg::item_type           b_item;
   logic                          rd_en;
   logic [csmth_pkg::COL_W-1:0]   rd_addr;

   // clamp geometry writes to the supported range
   assign wr_width  = csr_wdata[csmth_pkg::GW_W-1:0];
   assign wr_height = csr_wdata[csmth_pkg::GH_W-1:0];

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      close_limit_in = close_limit_ff;
      open_limit_in  = open_limit_ff;
      restart        = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            csmth_pkg::CSR_GRID_WIDTH: begin
               restart = 1'b1;
               if (wr_width < csmth_pkg::MIN_GW) begin
                  grid_width_in = csmth_pkg::MIN_GW;
               end else if (wr_width > csmth_pkg::MAX_GW) begin
                  grid_width_in = csmth_pkg::MAX_GW;
               end else begin
                  grid_width_in = wr_width;
               end
            end
            csmth_pkg::CSR_GRID_HEIGHT: begin
               restart = 1'b1;
               if (wr_height < csmth_pkg::MIN_GH) begin
                  grid_height_in = csmth_pkg::MIN_GH;
               end else if (wr_height > csmth_pkg::MAX_GH) begin
                  grid_height_in = csmth_pkg::MAX_GH;
               end else begin
                  grid_height_in = wr_height;
               end
            end
            csmth_pkg::CSR_CLOSE_LIMIT: begin
               close_limit_in = csr_wdata[csmth_pkg::LIMIT_W-1:0];
            end
            csmth_pkg::CSR_OPEN_LIMIT: begin
               open_limit_in = csr_wdata[csmth_pkg::LIMIT_W-1:0];
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= csmth_pkg::RST_GW;
         grid_height_ff <= csmth_pkg::RST_GH;
         close_limit_ff <= csmth_pkg::RST_CLOSE;
         open_limit_ff  <= csmth_pkg::RST_OPEN;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         close_limit_ff <= close_limit_in;
         open_limit_ff  <= open_limit_in;
      end
   end

   csmth_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_cell_in (req_cell_in),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .restart     (restart),
      .b_go        (b_go),
      .b_valid     (b_valid),
      .b_item      (b_item),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   csmth_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .b_valid       (b_valid),
      .b_item        (b_item),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .close_limit   (close_limit_ff),
      .open_limit    (open_limit_ff),
      .b_go          (b_go),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_out  (rsp_cell_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
